// File: sv/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/rcm_pkg.sv
// Package: types and constants of the rotor cipher machine
`default_nettype none
package rcm_pkg;
    localparam int SlotCount    = 5;
    localparam int RotorLibrary = 16;
    localparam int Alphabet     = 26;
    localparam int LW = 5;
    localparam int RW = 4;
    localparam int SW = 3;
    localparam int MapDepth = RotorLibrary * Alphabet;
    localparam int MW = $clog2(MapDepth);

    localparam logic [1:0] CMD_MAP    = 2'd0;
    localparam logic [1:0] CMD_ATTR   = 2'd1;
    localparam logic [1:0] CMD_LETTER = 2'd2;

    localparam logic [1:0] SEL_PLUG_FWD  = 2'd0;
    localparam logic [1:0] SEL_PLUG_BWD  = 2'd1;
    localparam logic [1:0] SEL_ROTOR_FWD = 2'd2;
    localparam logic [1:0] SEL_ROTOR_BWD = 2'd3;

    localparam logic [2:0] REG_SLOTS = 3'd0;
    localparam logic [2:0] REG_FAST  = 3'd1;
    localparam logic [2:0] REG_MODE  = 3'd2;
    localparam logic [2:0] REG_ROTOR = 3'd3;
    localparam logic [2:0] REG_RING  = 3'd4;
    localparam logic [2:0] REG_START = 3'd5;

    typedef logic [LW-1:0] t_letter;

    // (a + b) mod Alphabet for a, b below Alphabet
    function automatic t_letter add_mod(input t_letter a, input t_letter b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LW+1)'(Alphabet)) s = s - (LW+1)'(Alphabet);
        return s[LW-1:0];
    endfunction

    // (a - b) mod Alphabet for a, b below Alphabet
    function automatic t_letter sub_mod(input t_letter a, input t_letter b);
        logic [LW:0] s;
        s = {1'b0, a} + (LW+1)'(Alphabet) - {1'b0, b};
        if (s >= (LW+1)'(Alphabet)) s = s - (LW+1)'(Alphabet);
        return s[LW-1:0];
    endfunction

    // Reduce a five-bit field modulo Alphabet
    function automatic t_letter red_mod(input t_letter a);
        return (a >= LW'(Alphabet)) ? LW'(a - LW'(Alphabet)) : a;
    endfunction
endpackage
`default_nettype wire

// File: sv/rcm_maps.sv
// Wiring memories: plugboard and rotor maps behind a single shared read port
`default_nettype none
module rcm_maps (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [1:0]             i_wsel,
    input  wire logic [rcm_pkg::MW-1:0] i_waddr,
    input  wire rcm_pkg::t_letter       i_wdata,
    input  wire logic                   i_rd_rotor,
    input  wire logic                   i_rd_bwd,
    input  wire logic [rcm_pkg::MW-1:0] i_raddr,
    output      rcm_pkg::t_letter       o_rdata
);
    import rcm_pkg::*;

    t_letter r_plug_fwd [Alphabet];
    t_letter r_plug_bwd [Alphabet];
    t_letter r_rot_fwd  [MapDepth];
    t_letter r_rot_bwd  [MapDepth];
    t_letter r_pf_q, r_pb_q, r_rf_q, r_rb_q;
    logic    r_rotor_q, r_bwd_q;
    logic [LW-1:0] w_pidx, w_ridx;

    assign w_pidx = i_waddr[LW-1:0];
    assign w_ridx = i_raddr[LW-1:0];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            unique case (i_wsel)
                SEL_PLUG_FWD:  r_plug_fwd[w_pidx] <= i_wdata;
                SEL_PLUG_BWD:  r_plug_bwd[w_pidx] <= i_wdata;
                SEL_ROTOR_FWD: r_rot_fwd[i_waddr] <= i_wdata;
                SEL_ROTOR_BWD: r_rot_bwd[i_waddr] <= i_wdata;
                default: ;
            endcase
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_pf_q    <= r_plug_fwd[w_ridx];
        r_pb_q    <= r_plug_bwd[w_ridx];
        r_rf_q    <= r_rot_fwd[i_raddr];
        r_rb_q    <= r_rot_bwd[i_raddr];
        r_rotor_q <= i_rd_rotor;
        r_bwd_q   <= i_rd_bwd;
    end

    assign o_rdata = r_rotor_q ? (r_bwd_q ? r_rb_q : r_rf_q)
                               : (r_bwd_q ? r_pb_q : r_pf_q);
endmodule
`default_nettype wire

// File: sv/rotor_cipher_machine_unit.sv
// Top level: rotor cipher machine with memory-held wiring maps
//  channel | dir | handshake          | payload
//  input   | in  | i_valid / o_ready  | cmd, table fields, attributes, letter
//  result  | out | o_valid / i_ready  | o_cipher_letter
//  config  | in  | i_cfg_we           | i_cfg_index, i_cfg_data
// A write item leaves the block idle and ready for the next item. A letter passes the
// step state, then every map lookup puts its address on the single read port of the
// wiring memories and then takes the registered read data. Gear stepping holds the step
// state while a carry passes into the next slot. Reset is synchronous; maps are not cleared.
// A waiting result holds the block.
`default_nettype none
module rotor_cipher_machine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [1:0]  i_table_select,
    input  wire logic [3:0]  i_rotor_id,
    input  wire logic [4:0]  i_table_index,
    input  wire logic [4:0]  i_table_value,
    input  wire logic [25:0] i_turnover_mask,
    input  wire logic        i_rotating_flag,
    input  wire logic        i_message_start,
    input  wire logic [4:0]  i_plain_letter,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [4:0]  o_cipher_letter
);
    import rcm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STEP  = 6'b000010,
        S_PLUG  = 6'b000100,
        S_SLOT  = 6'b001000,
        S_PLUGB = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    logic [SW-1:0] r_slots, r_fast;
    logic    r_mode;
    logic [19:0] r_choice;
    logic [24:0] r_ring, r_start;
    t_letter r_pos [SlotCount];
    logic [25:0] r_turn [RotorLibrary];
    logic    r_rot [RotorLibrary];
    t_letter r_x;
    logic [SW-1:0] r_s;
    logic    r_bwd, r_wait;
    logic    r_ovalid;
    t_letter r_out;

    // Slot helpers
    function automatic logic [RW-1:0] rotor_of(input logic [19:0] c, input logic [SW-1:0] s);
        return c[RW*s +: RW];
    endfunction
    function automatic t_letter ring_of(input logic [24:0] g, input logic [SW-1:0] s);
        return red_mod(g[LW*s +: LW]);
    endfunction

    logic [SW-1:0] w_f, w_n;
    assign w_f = (r_fast > SW'(SlotCount-1)) ? SW'(SlotCount-1) : r_fast;
    assign w_n = (r_slots > SW'(SlotCount)) ? SW'(SlotCount) : r_slots;

    logic w_acc;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_acc   = i_valid && o_ready;

    // Memory port control
    logic w_we, w_rd_rotor, w_rd_bwd;
    logic [MW-1:0] w_waddr, w_raddr;
    t_letter w_rdata, w_ring, w_pos, w_in;
    assign w_we = w_acc && i_cmd == CMD_MAP && i_table_index < LW'(Alphabet);
    // Plugboard entries are addressed by the letter alone
    assign w_waddr = i_table_select[1]
                   ? MW'(i_rotor_id) * MW'(Alphabet) + MW'(i_table_index)
                   : MW'(i_table_index);
    assign w_ring = ring_of(r_ring, r_s);
    assign w_pos  = r_pos[r_s];
    assign w_in   = add_mod(r_x, sub_mod(w_pos, w_ring));

    always_comb begin
        w_rd_rotor = (r_state == S_SLOT);
        w_rd_bwd   = (r_state == S_SLOT) ? r_bwd : (r_state == S_PLUGB);
        if (r_state == S_SLOT)
            w_raddr = MW'(rotor_of(r_choice, r_s)) * MW'(Alphabet) + MW'(w_in);
        else
            w_raddr = MW'(r_x);
    end

    rcm_maps u_maps (
        .i_clk(i_clk), .i_we(w_we), .i_wsel(i_table_select), .i_waddr(w_waddr),
        .i_wdata(red_mod(i_table_value)), .i_rd_rotor(w_rd_rotor), .i_rd_bwd(w_rd_bwd),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SW'(5); r_fast <= SW'(3); r_mode <= 1'b0;
            r_choice <= '0; r_ring <= '0; r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SLOTS: r_slots  <= i_cfg_data[SW-1:0];
                REG_FAST:  r_fast   <= i_cfg_data[SW-1:0];
                REG_MODE:  r_mode   <= i_cfg_data[0];
                REG_ROTOR: r_choice <= i_cfg_data[19:0];
                REG_RING:  r_ring   <= i_cfg_data;
                REG_START: r_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rotor attributes
    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd == CMD_ATTR) begin
            r_turn[i_rotor_id] <= i_turnover_mask;
            r_rot[i_rotor_id]  <= i_rotating_flag;
        end
    end

    // Stepping terms for the current fast slot and, in gear mode, the current slot
    logic w_t0, w_t1, w_gear_carry;
    t_letter w_nx_f, w_nx_f1, w_nx_f2, w_nx_s;
    always_comb begin
        w_t0 = (w_f >= SW'(1)) && r_turn[rotor_of(r_choice, w_f - SW'(1))][r_pos[w_f - SW'(1)]];
        w_t1 = (w_f >= SW'(1)) && r_turn[rotor_of(r_choice, w_f)][r_pos[w_f]];
        w_gear_carry = (r_s > '0) && r_rot[rotor_of(r_choice, r_s - SW'(1))]
                       && r_turn[rotor_of(r_choice, r_s)][r_pos[r_s]];
        w_nx_s = add_mod(r_pos[r_s], LW'(1));
        w_nx_f = add_mod(r_pos[w_f], LW'(1));
        w_nx_f1 = add_mod(r_pos[w_f - SW'(1)], LW'(1));
        w_nx_f2 = add_mod(r_pos[w_f - SW'(2)], LW'(1));
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc && i_cmd == CMD_LETTER) n_state = S_STEP;
            S_STEP:  if (r_mode == 1'b0 || !w_gear_carry) n_state = S_PLUG;
            S_PLUG:  if (r_wait) n_state = (w_n == '0) ? S_PLUGB : S_SLOT;
            S_SLOT:  if (r_wait && r_bwd && r_s + SW'(1) >= w_n) n_state = S_PLUGB;
                     else if (r_wait && !r_bwd && r_s == '0 && w_n < SW'(2)) n_state = S_PLUGB;
            S_PLUGB: if (r_wait) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wait <= 1'b0;
            for (int k = 0; k < SlotCount; k++) r_pos[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_wait <= 1'b0;
                    if (w_acc && i_cmd == CMD_LETTER) begin
                        r_x <= red_mod(i_plain_letter);
                        r_s <= w_f;
                        if (i_message_start)
                            for (int k = 0; k < SlotCount; k++)
                                r_pos[k] <= red_mod(r_start[LW*k +: LW]);
                    end
                end
                S_STEP: begin
                    if (r_mode == 1'b0) begin
                        if (w_t0) begin
                            r_pos[w_f - SW'(1)] <= w_nx_f1;
                            if (w_f >= SW'(2)) r_pos[w_f - SW'(2)] <= w_nx_f2;
                        end else if (w_t1) begin
                            r_pos[w_f - SW'(1)] <= w_nx_f1;
                        end
                        r_pos[w_f] <= w_nx_f;
                    end else begin
                        r_pos[r_s] <= w_nx_s;
                        if (w_gear_carry) r_s <= r_s - SW'(1);
                    end
                end
                S_PLUG: begin
                    r_wait <= !r_wait;
                    r_s <= w_n - SW'(1);
                    r_bwd <= 1'b0;
                    if (r_wait) r_x <= w_rdata;
                end
                S_SLOT: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        r_x <= add_mod(w_rdata, sub_mod(w_ring, w_pos));
                        if (!r_bwd && r_s == '0) begin
                            r_bwd <= 1'b1;
                            r_s <= SW'(1);
                        end else if (!r_bwd) r_s <= r_s - SW'(1);
                        else r_s <= r_s + SW'(1);
                    end
                end
                S_PLUGB: begin
                    r_wait <= !r_wait;
                    if (r_wait) r_out <= w_rdata;
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // The slot readout state holds across the lookup wait
    assign o_valid = r_ovalid;
    assign o_cipher_letter = r_out;
endmodule
`default_nettype wire

// File: sv/rcm_checker.sv
// Port checker for the rotor cipher machine, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rcm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [1:0] i_cmd,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [4:0] o_cipher_letter
);
    import rcm_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_cipher_letter), "result dropped")
    `ASSERT_IMPL(a_no_ready_busy, i_clk, i_rst_n, o_valid, !o_ready, "accepting while result waits")
    `ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && o_ready && i_cmd == CMD_LETTER, !o_ready, "accepted during a letter")
    `ASSERT_IMPL(a_letter_range, i_clk, i_rst_n, o_valid, o_cipher_letter < 5'd26, "letter out of range")
endmodule
bind rotor_cipher_machine_unit rcm_checker u_rcm_checker (.*);
`default_nettype wire
